/* hw/rtl/dsg_pkg.sv */
`timescale 1ns / 1ps

package dsg_pkg;

    localparam int MAX_JOINTS     = 4;
    localparam int NUM_JOINTS_DEF = 4;
    localparam int PHASE_W        = 32;
    localparam int POS_W          = 32;
    localparam int HOLD_W         = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 8;

    localparam logic [MAX_JOINTS-1:0] MASK_RESET = 4'hF;
    localparam logic [HOLD_W-1:0]     HOLD_RESET = 8'd2;

    // Register indexes of the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_JOINT_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_HOLD   = 2'd1;

    // Per-lane report toward the merge stage (state after this tick)
    typedef struct packed {
        logic                    step;
        logic                    forward;
        logic signed [POS_W-1:0] position;
    } t_lane_stat;

endpackage

/* hw/rtl/dsg_in_if.sv */
`timescale 1ns / 1ps

interface dsg_in_if import dsg_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      enable;
    logic signed [PHASE_W-1:0] increment_0;
    logic signed [PHASE_W-1:0] increment_1;
    logic signed [PHASE_W-1:0] increment_2;
    logic signed [PHASE_W-1:0] increment_3;

    modport source (output valid, enable, increment_0, increment_1, increment_2,
                    increment_3, input ready);
    modport sink   (input valid, enable, increment_0, increment_1, increment_2,
                    increment_3, output ready);
endinterface

/* hw/rtl/dsg_out_if.sv */
`timescale 1ns / 1ps

interface dsg_out_if import dsg_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [MAX_JOINTS-1:0]   step_mask;
    logic [MAX_JOINTS-1:0]   direction_mask;
    logic                    driver_enable_n;
    logic signed [POS_W-1:0] position_0;
    logic signed [POS_W-1:0] position_1;
    logic signed [POS_W-1:0] position_2;
    logic signed [POS_W-1:0] position_3;

    modport source (output valid, step_mask, direction_mask, driver_enable_n,
                    position_0, position_1, position_2, position_3, input ready);
    modport sink   (input valid, step_mask, direction_mask, driver_enable_n,
                    position_0, position_1, position_2, position_3, output ready);
endinterface

/* hw/rtl/dsg_cfg_if.sv */
`timescale 1ns / 1ps

interface dsg_cfg_if import dsg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/dsg_lane.sv */
`timescale 1ns / 1ps

module dsg_lane
    import dsg_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic signed [PHASE_W-1:0] i_increment,
    input  logic [HOLD_W-1:0]         i_hold_ticks,
    output t_lane_stat                o_stat
);

    logic [PHASE_W-1:0]      r_acc, n_acc;
    logic                    r_fwd, n_fwd;
    logic [HOLD_W-1:0]       r_hold, n_hold;
    logic                    r_pend, n_pend;
    logic signed [POS_W-1:0] r_pos, n_pos;

    logic               neg;
    logic [PHASE_W-1:0] mag;
    logic               fwd_new;
    logic               dir_chg;
    logic [HOLD_W-1:0]  hold_mid;
    logic [PHASE_W:0]   sum;
    logic               pend_mid;
    logic               step;

    always_comb begin
        neg      = i_increment[PHASE_W-1];
        // Two's complement of the most negative value is itself: already the limit
        mag      = neg ? (~i_increment + 1'b1) : i_increment;
        fwd_new  = neg ? 1'b0 : ((i_increment != '0) ? 1'b1 : r_fwd);
        dir_chg  = (fwd_new != r_fwd);
        hold_mid = dir_chg ? i_hold_ticks : r_hold;
        sum      = {1'b0, r_acc} + {1'b0, mag};
        pend_mid = r_pend | sum[PHASE_W];

        n_acc  = r_acc;
        n_fwd  = r_fwd;
        n_hold = r_hold;
        n_pend = r_pend;
        n_pos  = r_pos;
        step   = 1'b0;
        if (i_go) begin
            n_acc  = sum[PHASE_W-1:0];
            n_fwd  = fwd_new;
            n_pend = pend_mid;
            if (hold_mid != '0) begin
                n_hold = hold_mid - 1'b1;
            end else begin
                n_hold = hold_mid;
                if (pend_mid) begin
                    n_pend = 1'b0;
                    step   = 1'b1;
                    n_pos  = fwd_new ? (r_pos + POS_W'(1)) : (r_pos - POS_W'(1));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_fwd  <= 1'b1;
            r_hold <= '0;
            r_pend <= 1'b0;
            r_pos  <= '0;
        end else begin
            r_acc  <= n_acc;
            r_fwd  <= n_fwd;
            r_hold <= n_hold;
            r_pend <= n_pend;
            r_pos  <= n_pos;
        end
    end

    assign o_stat.step     = step;
    assign o_stat.forward  = n_fwd;
    assign o_stat.position = n_pos;

    a_step_needs_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |-> i_go)
        else $error("step pulse on a tick that was not serviced");

    a_pos_moves_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_pos != $past(r_pos)) |-> $past(step))
        else $error("position moved without a step");

    a_hold_blocks_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && dir_chg && (i_hold_ticks != '0) |-> !step)
        else $error("step issued inside direction hold");

endmodule

/* hw/rtl/dsg_merge.sv */
`timescale 1ns / 1ps

module dsg_merge
    import dsg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_lane_stat              i_stat [MAX_JOINTS],
    input  logic                    i_fire,
    input  logic                    i_enable,
    input  logic                    i_out_ready,
    output logic                    o_in_ready,
    output logic                    o_valid,
    output logic [MAX_JOINTS-1:0]   o_step_mask,
    output logic [MAX_JOINTS-1:0]   o_direction_mask,
    output logic                    o_driver_enable_n,
    output logic signed [POS_W-1:0] o_position [MAX_JOINTS]
);

    logic                    r_valid;
    logic [MAX_JOINTS-1:0]   r_step;
    logic [MAX_JOINTS-1:0]   r_dir;
    logic                    r_den_n;
    logic signed [POS_W-1:0] r_pos [MAX_JOINTS];

    assign o_in_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload: capture the lane reports on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_den_n <= !i_enable;
            for (int j = 0; j < MAX_JOINTS; j++) begin
                r_step[j] <= i_stat[j].step;
                r_dir[j]  <= i_stat[j].forward;
                r_pos[j]  <= i_stat[j].position;
            end
        end
    end

    assign o_valid           = r_valid;
    assign o_step_mask       = r_step;
    assign o_direction_mask  = r_dir;
    assign o_driver_enable_n = r_den_n;
    assign o_position        = r_pos;

endmodule

/* hw/rtl/dds_step_pulse_generator.sv */
`timescale 1ns / 1ps

// Channel  | Dir | Handshake      | Payload
// ---------+-----+----------------+----------------------------------------------
// i_in     | in  | valid / ready  | enable, increment_0..3 (one base tick)
// o_out    | out | valid / ready  | step_mask, direction_mask, driver_enable_n,
//          |     |                | position_0..3
// i_cfg    | in  | valid / ready  | index (0 joint mask, 1 hold ticks), data
//
// One tick accepted per cycle unless the output register is stalled; its result
// appears in the output register on the next cycle. The rate is set by the per-lane
// accumulator/direction/position update, which closes on its own state registers.
// Synchronous active-low reset clears lane state (forward set), mask all joints, hold 2.
// A stalled output holds its transaction; input stays ready while the output
// register drains in the same cycle. Configuration is always ready.

module dds_step_pulse_generator
    import dsg_pkg::*;
#(
    parameter int NUM_JOINTS = NUM_JOINTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dsg_in_if.sink     i_in,
    dsg_out_if.source  o_out,
    dsg_cfg_if.sink    i_cfg
);

    logic [MAX_JOINTS-1:0] r_joint_mask;
    logic [HOLD_W-1:0]     r_hold_ticks;

    logic                      in_ready;
    logic                      fire;
    logic signed [PHASE_W-1:0] incr [MAX_JOINTS];
    t_lane_stat                stat [MAX_JOINTS];
    logic signed [POS_W-1:0]   pos  [MAX_JOINTS];

    // Configuration: take every write, drop indexes beyond the register list
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_joint_mask <= MASK_RESET;
            r_hold_ticks <= HOLD_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_JOINT_MASK: r_joint_mask <= i_cfg.data[MAX_JOINTS-1:0];
                CFG_DIR_HOLD:   r_hold_ticks <= i_cfg.data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = in_ready;
    assign fire       = i_in.valid && in_ready;

    assign incr[0] = i_in.increment_0;
    assign incr[1] = i_in.increment_1;
    assign incr[2] = i_in.increment_2;
    assign incr[3] = i_in.increment_3;

    // Lanes: one per joint that exists; a lane advances only on an enabled tick
    // for a joint present in the mask, otherwise it holds and reports its state.
    for (genvar j = 0; j < MAX_JOINTS; j++) begin : g_lane
        if (j < NUM_JOINTS) begin : g_on
            dsg_lane u_lane (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_go         (fire && i_in.enable && r_joint_mask[j]),
                .i_increment  (incr[j]),
                .i_hold_ticks (r_hold_ticks),
                .o_stat       (stat[j])
            );
        end else begin : g_off
            // Joint not built: report zeros
            assign stat[j] = '0;
        end
    end

    dsg_merge u_merge (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_stat            (stat),
        .i_fire            (fire),
        .i_enable          (i_in.enable),
        .i_out_ready       (o_out.ready),
        .o_in_ready        (in_ready),
        .o_valid           (o_out.valid),
        .o_step_mask       (o_out.step_mask),
        .o_direction_mask  (o_out.direction_mask),
        .o_driver_enable_n (o_out.driver_enable_n),
        .o_position        (pos)
    );

    assign o_out.position_0 = pos[0];
    assign o_out.position_1 = pos[1];
    assign o_out.position_2 = pos[2];
    assign o_out.position_3 = pos[3];

endmodule
